// ----- src/bmat_pkg.sv -----
// Shared types, constants and reset helpers for the banked MMU address translator.
// No dependencies; every other file imports this package.
`default_nettype none

package bmat_pkg;

    localparam int ADDR_W          = 16;
    localparam int DATA_W          = 8;
    localparam int PA_W            = 21;
    localparam int SLOT_W          = 3;
    localparam int OFF_W           = 13;
    localparam int SLOTS_PER_TABLE = 8;
    localparam int TABLE_COUNT_DEF = 4;
    localparam int TBL_IDX_MAX_W   = 5;   // 2-bit table select + slot

    // control byte addresses and bits
    localparam logic [ADDR_W-1:0] MC_ADDR     = 16'h0000;
    localparam logic [ADDR_W-1:0] IO_ADDR     = 16'h0001;
    localparam int                MC_EDIT_BIT = 7;
    localparam int                IO_DIS_BIT  = 2;

    // slot 6 I/O window
    localparam logic [SLOT_W-1:0] IO_SLOT     = 3'd6;
    localparam logic [ADDR_W-1:0] IO_BASE     = 16'hC000;
    localparam logic [ADDR_W-1:0] IO0_END_A   = 16'hD400;
    localparam logic [ADDR_W-1:0] IO0_BASE_B  = 16'hD800;
    localparam logic [ADDR_W-1:0] IO0_END_B   = 16'hD880;

    localparam logic [DATA_W-1:0] FLASH_PAGE_BASE = 8'h40;
    localparam logic [DATA_W-1:0] LAST_SLOT_PAGE  = 8'h7F;

    typedef enum logic [2:0] {
        TGT_RAM   = 3'd0,
        TGT_FLASH = 3'd1,
        TGT_IO0   = 3'd2,
        TGT_IO1   = 3'd3,
        TGT_IO2   = 3'd4,
        TGT_IO3   = 3'd5,
        TGT_TABLE = 3'd6,
        TGT_NONE  = 3'd7
    } target_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] cpu_address;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        target_t           target;
        logic [PA_W-1:0]   physical_address;
        logic [DATA_W-1:0] block_read_data;
    } result_t;

    typedef struct packed {
        logic                     mc_we;
        logic                     io_we;
        logic                     tbl_we;
        logic [TBL_IDX_MAX_W-1:0] idx;
        logic [DATA_W-1:0]        data;
    } wr_req_t;

    // reset page of a slot entry: identity, last slot points at the top flash page
    function automatic logic [DATA_W-1:0] bank_reset(input logic [SLOT_W-1:0] slot);
        logic [DATA_W-1:0] page;
        page = (slot == 3'd7) ? LAST_SLOT_PAGE : {5'b0, slot};
        return page;
    endfunction

endpackage

`default_nettype wire

// ----- src/bmat_req_if.sv -----
// Request channel: one bus access per transfer.
// Depends on bmat_pkg.
`default_nettype none

interface bmat_req_if
    import bmat_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output action, output cpu_address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input cpu_address, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ----- src/bmat_rsp_if.sv -----
// Response channel: one decoded result per transfer.
// Depends on bmat_pkg.
`default_nettype none

interface bmat_rsp_if
    import bmat_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        target;
    logic [PA_W-1:0]   physical_address;
    logic [DATA_W-1:0] block_read_data;

    modport source (output valid, output target, output physical_address,
                    output block_read_data, input ready);
    modport sink   (input valid, input target, input physical_address,
                    input block_read_data, output ready);
endinterface

`default_nettype wire

// ----- src/banked_mmu_address_translator_top.sv -----
// Top level of the banked MMU address translator: input stage, decode, result stage.
// Depends on bmat_pkg, bmat_req_if, bmat_rsp_if, bmat_regs, bmat_decode.
//
//  channel | dir | transfer carries
//  --------+-----+--------------------------------------------------
//  req     | in  | action, cpu_address, write_data (one bus access)
//  rsp     | out | target, physical_address, block_read_data
//
// Each access passes through the input stage and then the result stage, at one
// access per clock sustained while rsp is not stalled.
// Table and control-byte writes take effect when the access leaves the input
// stage, so the next access already sees them.
// Reset (rst_n low, asynchronous) empties both stages, clears the control bytes
// and loads every table with its default page map.
// A stalled rsp holds the result stage; the input stage still drains into it in
// the same cycle the result is taken, so req.ready only drops under a full stall.
`default_nettype none

module banked_mmu_address_translator_top
    import bmat_pkg::*;
#(
    parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmat_req_if.sink   req,
    bmat_rsp_if.source rsp
);
    logic              in_valid_reg;
    logic              in_valid_next;
    access_t           in_acc_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;

    logic              in_take;
    logic              in_move;

    logic [TBL_IDX_MAX_W-1:0] rd_idx;
    logic [DATA_W-1:0]        rd_data;
    logic [DATA_W-1:0]        memory_control;
    logic [DATA_W-1:0]        io_control;
    wr_req_t                  dec_wr;
    wr_req_t                  commit_wr;
    result_t                  dec_res;

    // input stage moves on when the result stage is empty or being emptied
    assign in_move   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || in_move;
    assign in_take   = req.valid && req.ready;

    assign in_valid_next  = in_take || (in_valid_reg && !in_move);
    assign out_valid_next = in_move || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_acc_reg <= '{action: req.action, cpu_address: req.cpu_address,
                            write_data: req.write_data};
        end
        if (in_move)
        begin
            out_res_reg <= dec_res;
        end
    end

    // state changes only when the access is committed to the result stage
    always_comb
    begin
        commit_wr        = dec_wr;
        commit_wr.mc_we  = dec_wr.mc_we  && in_move;
        commit_wr.io_we  = dec_wr.io_we  && in_move;
        commit_wr.tbl_we = dec_wr.tbl_we && in_move;
    end

    bmat_regs #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (commit_wr),
        .rd_idx         (rd_idx),
        .rd_data        (rd_data),
        .memory_control (memory_control),
        .io_control     (io_control)
    );

    bmat_decode #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_decode (
        .acc            (in_acc_reg),
        .memory_control (memory_control),
        .io_control     (io_control),
        .rd_data        (rd_data),
        .rd_idx         (rd_idx),
        .wr             (dec_wr),
        .res            (dec_res)
    );

    assign rsp.valid            = out_valid_reg;
    assign rsp.target           = out_res_reg.target;
    assign rsp.physical_address = out_res_reg.physical_address;
    assign rsp.block_read_data  = out_res_reg.block_read_data;

endmodule

`default_nettype wire

// ----- src/bmat_regs.sv -----
// Bank tables and control-byte shadows, one combinational read port.
// Depends on bmat_pkg.
`default_nettype none

module bmat_regs
    import bmat_pkg::*;
#(
    parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire wr_req_t                  wr,
    input  wire logic [TBL_IDX_MAX_W-1:0] rd_idx,
    output logic [DATA_W-1:0]             rd_data,
    output logic [DATA_W-1:0]             memory_control,
    output logic [DATA_W-1:0]             io_control
);
    localparam int DEPTH = TABLE_COUNT * SLOTS_PER_TABLE;
    localparam int IDX_W = $clog2(DEPTH);

    logic [DATA_W-1:0] tbl_reg [DEPTH];
    logic [DATA_W-1:0] memory_control_reg;
    logic [DATA_W-1:0] io_control_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tbl_reg[i] <= bank_reset(SLOT_W'(i));
            end
            memory_control_reg <= '0;
            io_control_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (wr.tbl_we && (wr.idx[IDX_W-1:0] == IDX_W'(i)))
                begin
                    tbl_reg[i] <= wr.data;
                end
            end
            if (wr.mc_we)
            begin
                memory_control_reg <= wr.data;
            end
            if (wr.io_we)
            begin
                io_control_reg <= wr.data;
            end
        end
    end

    assign rd_data        = tbl_reg[rd_idx[IDX_W-1:0]];
    assign memory_control = memory_control_reg;
    assign io_control     = io_control_reg;

endmodule

`default_nettype wire

// ----- src/bmat_decode.sv -----
// Combinational decode of one access against the current control bytes and table.
// Depends on bmat_pkg.
`default_nettype none

module bmat_decode
    import bmat_pkg::*;
#(
    parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
    input  wire access_t                  acc,
    input  wire logic [DATA_W-1:0]        memory_control,
    input  wire logic [DATA_W-1:0]        io_control,
    input  wire logic [DATA_W-1:0]        rd_data,
    output logic [TBL_IDX_MAX_W-1:0]      rd_idx,
    output wr_req_t                       wr,
    output result_t                       res
);
    logic [ADDR_W-1:0]        a;
    logic [1:0]               edit_sel;
    logic [1:0]               map_sel;
    logic [TBL_IDX_MAX_W-1:0] edit_idx;
    logic [TBL_IDX_MAX_W-1:0] map_idx;
    logic                     is_ctrl;
    logic                     is_win;
    logic                     io_mapped;
    logic                     io0_present;
    logic [PA_W-1:0]          io_off;
    logic [PA_W-1:0]          mapped_pa;

    // fold a 2-bit table selector onto the tables present (at most three subtracts)
    function automatic logic [1:0] wrap_sel(input logic [1:0] sel);
        logic [2:0] v;
        v = {1'b0, sel};
        for (int k = 0; k < 3; k++)
        begin
            if (v >= 3'(TABLE_COUNT))
            begin
                v = v - 3'(TABLE_COUNT);
            end
        end
        return v[1:0];
    endfunction

    assign a        = acc.cpu_address;
    // selector beyond the implemented tables wraps
    assign edit_sel = wrap_sel(memory_control[5:4]);
    assign map_sel  = wrap_sel(memory_control[1:0]);
    assign edit_idx = {edit_sel, a[SLOT_W-1:0]};
    assign map_idx  = {map_sel, a[ADDR_W-1 -: SLOT_W]};

    assign is_ctrl = (a[ADDR_W-1:3] == '0);
    assign is_win  = (a[ADDR_W-1:4] == '0) && a[3];
    assign rd_idx  = is_win ? edit_idx : map_idx;

    assign io_mapped   = (a[ADDR_W-1 -: SLOT_W] == IO_SLOT) && !io_control[IO_DIS_BIT];
    assign io0_present = (a < IO0_END_A) || ((a >= IO0_BASE_B) && (a < IO0_END_B));
    assign io_off      = PA_W'(a - IO_BASE);
    assign mapped_pa   = {rd_data, a[OFF_W-1:0]};

    always_comb
    begin
        wr      = '0;
        wr.data = acc.write_data;
        wr.idx  = edit_idx;
        res     = '{target: TGT_RAM, physical_address: PA_W'(a), block_read_data: '0};

        if (is_ctrl)
        begin
            wr.mc_we = acc.action && (a == MC_ADDR);
            wr.io_we = acc.action && (a == IO_ADDR);
        end
        else if (is_win)
        begin
            if (memory_control[MC_EDIT_BIT])
            begin
                res.target           = TGT_TABLE;
                res.physical_address = PA_W'(edit_idx);
                if (acc.action)
                begin
                    wr.tbl_we = 1'b1;
                end
                else
                begin
                    res.block_read_data = rd_data;
                end
            end
        end
        else if (rd_data >= FLASH_PAGE_BASE)
        begin
            // flash wins over I/O redirection
            res.target           = TGT_FLASH;
            res.physical_address = mapped_pa;
        end
        else if (io_mapped)
        begin
            res.physical_address = io_off;
            case (io_control[1:0])
                2'd1:    res.target = TGT_IO1;
                2'd2:    res.target = TGT_IO2;
                2'd3:    res.target = TGT_IO3;
                default:
                begin
                    if (io0_present)
                    begin
                        res.target = TGT_IO0;
                    end
                    else
                    begin
                        res.target           = TGT_NONE;
                        res.physical_address = '0;
                    end
                end
            endcase
        end
        else
        begin
            res.physical_address = mapped_pa;
        end
    end

endmodule

`default_nettype wire

// ----- src/bmat_checker.sv -----
// Port-level checks for the translator, bound to the top level.
// Depends on bmat_pkg and banked_mmu_address_translator_top.
`default_nettype none

module bmat_checker
    import bmat_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [2:0]        target,
    input wire logic [PA_W-1:0]   physical_address,
    input wire logic [DATA_W-1:0] block_read_data
);
    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(target)
            && $stable(physical_address) && $stable(block_read_data))
        else $error("rsp changed while stalled");

    // a fresh result follows an accepted access through the input stage and the result stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without matching request transfer");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (target == TGT_NONE) |-> (physical_address == '0)
            && (block_read_data == '0))
        else $error("no-device result carries address or data");

    a_data_table_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (target != TGT_TABLE) |-> (block_read_data == '0))
        else $error("read data outside a table access");

endmodule

bind banked_mmu_address_translator_top bmat_checker u_bmat_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .target           (rsp.target),
    .physical_address (rsp.physical_address),
    .block_read_data  (rsp.block_read_data)
);

`default_nettype wire

// ----- tb/banked_mmu_address_translator_top_tb.sv -----
// Self-checking testbench for banked_mmu_address_translator_top: directed and random bus accesses,
// an in-bench decode predictor and an in-order result check.
// Depends on bmat_pkg, bmat_req_if, bmat_rsp_if and the block itself.
`timescale 1ns / 1ps

module banked_mmu_address_translator_top_tb;
    import bmat_pkg::*;

    // bus access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam int TABLES       = TABLE_COUNT_DEF;
    localparam int TABLE_DEPTH  = TABLES * SLOTS_PER_TABLE;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_LEN    = 125;
    localparam int TAIL_CYCLES  = 8;        // two-stage pipe, plus margin
    localparam int CYCLE_LIMIT  = 200000;

    // idling per phase: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    localparam int SEND_GAP_PCT [4] = '{0, 56, 0, 36};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 56, 36};

    // one queued access, with the idling phase it belongs to and a flag that
    // holds it back until every outstanding result has come back
    typedef struct packed {
        access_t    acc;
        logic [1:0] phase;
        logic       drain;
    } stim_t;

    logic clk;
    logic rst_n;

    bmat_req_if req ();
    bmat_rsp_if rsp ();

    banked_mmu_address_translator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    stim_t       access_q[$];     // accesses still to be driven
    result_t     decode_q[$];     // predicted decodes, oldest first
    logic [1:0]  cur_phase = 2'd0;
    int unsigned n_errors  = 0;
    int unsigned n_cycles  = 0;

    // predictor's own copy of the mapping state
    logic [DATA_W-1:0] slot_page [TABLE_DEPTH];
    logic [DATA_W-1:0] mem_ctl;
    logic [DATA_W-1:0] io_ctl;

    // ------------------------------------------------------------------
    // Decode predictor. Updates the shadow state as the block would and
    // returns the result the access must produce.
    // ------------------------------------------------------------------
    function automatic result_t translate_access(input access_t acc);
        result_t           res;
        int                idx;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] page;
        logic [ADDR_W-1:0] io_off;
        res.target           = TGT_RAM;
        res.physical_address = '0;
        res.block_read_data  = '0;
        if (acc.cpu_address < 16'd8)
        begin
            // control bytes: shadowed, but the transfer still lands in RAM
            if (acc.action == ACT_WRITE && acc.cpu_address == MC_ADDR)
                mem_ctl = acc.write_data;
            else if (acc.action == ACT_WRITE && acc.cpu_address == IO_ADDR)
                io_ctl = acc.write_data;
            res.physical_address = PA_W'(acc.cpu_address);
        end
        else if (acc.cpu_address < 16'd16)
        begin
            if (!mem_ctl[MC_EDIT_BIT])
                res.physical_address = PA_W'(acc.cpu_address);
            else
            begin
                // edit window: table picked by bits 5:4, folded onto the tables present
                idx = (int'(mem_ctl[5:4]) % TABLES) * SLOTS_PER_TABLE
                      + int'(acc.cpu_address[2:0]);
                res.target           = TGT_TABLE;
                res.physical_address = PA_W'(idx);
                if (acc.action == ACT_WRITE)
                    slot_page[idx] = acc.write_data;
                else
                    res.block_read_data = slot_page[idx];
            end
        end
        else
        begin
            slot = acc.cpu_address[ADDR_W-1:OFF_W];
            off  = acc.cpu_address[OFF_W-1:0];
            idx  = (int'(mem_ctl[1:0]) % TABLES) * SLOTS_PER_TABLE + int'(slot);
            page = slot_page[idx];
            if (page >= FLASH_PAGE_BASE)
            begin
                // flash wins over the I/O window
                res.target           = TGT_FLASH;
                res.physical_address = {page, off};
            end
            else if (slot == IO_SLOT && !io_ctl[IO_DIS_BIT])
            begin
                io_off = acc.cpu_address - IO_BASE;
                if (io_ctl[1:0] != 2'd0)
                begin
                    res.target           = target_t'(TGT_IO0 + io_ctl[1:0]);
                    res.physical_address = PA_W'(io_off);
                end
                else if ((acc.cpu_address >= IO_BASE && acc.cpu_address < IO0_END_A) ||
                         (acc.cpu_address >= IO0_BASE_B && acc.cpu_address < IO0_END_B))
                begin
                    res.target           = TGT_IO0;
                    res.physical_address = PA_W'(io_off);
                end
                else
                    res.target = TGT_NONE;   // hole in I/O page 0
            end
            else
                res.physical_address = {page, off};
        end
        return res;
    endfunction

    task automatic queue_access(input logic action, input logic [ADDR_W-1:0] address,
                                input logic [DATA_W-1:0] data, input logic [1:0] phase,
                                input logic drain);
        stim_t s;
        s.acc.action      = action;
        s.acc.cpu_address = address;
        s.acc.write_data  = data;
        s.phase           = phase;
        s.drain           = drain;
        access_q.push_back(s);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset. Reset is asserted once, at the start of the run.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.action      = ACT_READ;
        req.cpu_address = '0;
        req.write_data  = '0;
        rsp.ready       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("banked_mmu_address_translator_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents the head of access_q, predicts on every transfer.
    // valid gets at most one nonblocking assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        stim_t nxt;
        logic  give;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.action      <= ACT_READ;
            req.cpu_address <= '0;
            req.write_data  <= '0;
        end
        else
        begin
            give = 1'b0;
            if (req.valid && req.ready)
            begin
                nxt = access_q.pop_front();
                decode_q.push_back(translate_access(nxt.acc));
                cur_phase <= nxt.phase;
            end
            if ((!req.valid || req.ready) && access_q.size() != 0)
            begin
                nxt  = access_q[0];
                // a drain item waits for the pipe to empty before it goes out
                give = !(nxt.drain && decode_q.size() != 0) &&
                       ($urandom_range(99) >= SEND_GAP_PCT[nxt.phase]);
            end
            if (!req.valid || req.ready)
            begin
                req.valid <= give;
                if (give)
                begin
                    req.action      <= nxt.acc.action;
                    req.cpu_address <= nxt.acc.cpu_address;
                    req.write_data  <= nxt.acc.write_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction
    // and throttles ready according to the current phase.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (decode_q.size() == 0)
                begin
                    $error("unexpected result: target %0d, physical_address 0x%06h",
                           rsp.target, rsp.physical_address);
                    n_errors++;
                end
                else
                begin
                    want = decode_q.pop_front();
                    if (rsp.target !== want.target)
                    begin
                        $error("target: expected %0d, got %0d", want.target, rsp.target);
                        n_errors++;
                    end
                    if (rsp.physical_address !== want.physical_address)
                    begin
                        $error("physical_address: expected 0x%06h, got 0x%06h",
                               want.physical_address, rsp.physical_address);
                        n_errors++;
                    end
                    if (rsp.block_read_data !== want.block_read_data)
                    begin
                        $error("block_read_data: expected 0x%02h, got 0x%02h",
                               want.block_read_data, rsp.block_read_data);
                        n_errors++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= RECV_STALL_PCT[cur_phase]);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int          i;
        logic [1:0]  ph;
        logic        act;
        logic [15:0] address;
        logic [7:0]  data;

        // predictor reset state: identity map, last slot on the top flash page
        for (i = 0; i < TABLE_DEPTH; i++)
            slot_page[i] = (i % SLOTS_PER_TABLE == 7) ? LAST_SLOT_PAGE : DATA_W'(i % 8);
        mem_ctl = '0;
        io_ctl  = '0;

        // directed: reset map, I/O page 0 edges, redirection, I/O disabled,
        // edit window, flash in slot 6, top physical address, flash boundary
        queue_access(ACT_READ,  16'h0000, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'hFFFF, 8'hFF, 2'd0, 1'b0);  // slot 7 -> top flash page
        queue_access(ACT_READ,  16'hC000, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'hD400, 8'h00, 2'd0, 1'b0);  // first hole
        queue_access(ACT_READ,  16'hD87F, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'hD880, 8'h00, 2'd0, 1'b0);  // second hole
        queue_access(ACT_READ,  16'h0008, 8'h00, 2'd0, 1'b0);  // edit off: plain RAM
        queue_access(ACT_WRITE, 16'h000F, 8'hAA, 2'd0, 1'b0);
        queue_access(ACT_WRITE, IO_ADDR,  8'h03, 2'd0, 1'b0);  // I/O page 3
        queue_access(ACT_READ,  16'hDFFF, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, IO_ADDR,  8'h07, 2'd0, 1'b0);  // I/O disabled
        queue_access(ACT_WRITE, 16'hC123, 8'h55, 2'd0, 1'b0);  // lands in RAM
        queue_access(ACT_WRITE, MC_ADDR,  8'hB3, 2'd0, 1'b0);  // edit table 3, active 3
        queue_access(ACT_WRITE, 16'h000E, 8'hFF, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'h000E, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'hDFFF, 8'h00, 2'd0, 1'b0);  // flash page 0xFF in slot 6
        queue_access(ACT_WRITE, 16'h0008, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_READ,  16'h0010, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, MC_ADDR,  8'hFF, 2'd0, 1'b0);
        queue_access(ACT_WRITE, IO_ADDR,  8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, 16'h000E, 8'h3F, 2'd0, 1'b0);  // last RAM page
        queue_access(ACT_READ,  16'hD000, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, 16'h000D, 8'h40, 2'd0, 1'b0);  // first flash page
        queue_access(ACT_READ,  16'hA000, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, IO_ADDR,  8'hFA, 2'd0, 1'b0);  // I/O page 2
        queue_access(ACT_READ,  16'hC000, 8'h00, 2'd0, 1'b0);
        queue_access(ACT_WRITE, MC_ADDR,  8'h00, 2'd0, 1'b0);

        // random: mostly real traffic, with control and table writes mixed in
        // so that edit mode, table switching and I/O redirection keep changing
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            ph      = 2'((i / PHASE_LEN) % 4);
            act     = 1'($urandom_range(1));
            data    = 8'($urandom);
            address = 16'($urandom);
            case ($urandom_range(99)) inside
                [0:7]:
                begin
                    act     = ACT_WRITE;
                    address = MC_ADDR;
                end
                [8:11]:
                begin
                    act     = ACT_WRITE;
                    address = IO_ADDR;
                end
                [12:14]: address = 16'($urandom_range(7));
                [15:34]:
                begin
                    address = 16'($urandom_range(15, 8));
                    // keep a good share of pages in RAM
                    if ($urandom_range(1) == 1)
                        data = 8'($urandom_range(63));
                end
                [35:54]:
                begin
                    // slot 6, weighted towards the edges of the I/O page 0 windows
                    case ($urandom_range(7))
                        0:       address = 16'hD3FF + 16'($urandom_range(1));
                        1:       address = 16'hD7FF + 16'($urandom_range(1));
                        2:       address = 16'hD87F + 16'($urandom_range(1));
                        3:       address = IO_BASE;
                        4:       address = 16'hDFFF;
                        default: address = IO_BASE | 16'($urandom_range(16'h1FFF));
                    endcase
                end
                default: ;
            endcase
            queue_access(act, address, data, ph, (i % PHASE_LEN) == 0);
        end

        // everything driven, then everything back, then the pipe tail
        while (access_q.size() != 0 || req.valid)
            @(posedge clk);
        while (decode_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("banked_mmu_address_translator_top_tb: done, clean");
        else
            $display("banked_mmu_address_translator_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bmat_pkg.sv
src/bmat_req_if.sv
src/bmat_rsp_if.sv
src/bmat_regs.sv
src/bmat_decode.sv
src/banked_mmu_address_translator_top.sv
src/bmat_checker.sv
tb/banked_mmu_address_translator_top_tb.sv
